// ===== design/anbs_pkg.sv =====
// ============================================================================
// anbs_pkg - shared types and constants for the Annex B NAL splitter
// Beat layouts, configuration register indexes and reset values.
// ============================================================================
`default_nettype none

package anbs_pkg;

    // stream geometry
    localparam int unsigned HELD_DEPTH  = 4;
    localparam int unsigned MAX_RESULTS = HELD_DEPTH + 1;
    localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int unsigned HELD_CNT_W  = $clog2(HELD_DEPTH + 1);

    // configuration port
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MERGE_FIRST  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MERGE_SECOND = CFG_INDEX_W'(1);

    // default merge headers: SPS and PPS
    localparam logic [7:0] MERGE_FIRST_RST  = 8'h67;
    localparam logic [7:0] MERGE_SECOND_RST = 8'h68;

    // start code bytes
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] START_BYTE = 8'h01;

    // one held or emitted byte with its end-of-packet mark
    typedef struct packed {
        logic [7:0] data;
        logic       eop;
    } entry_t;

    // results produced by one input byte
    typedef struct packed {
        logic [COUNT_W-1:0]           count;
        entry_t [MAX_RESULTS-1:0]     entry;
    } group_t;

    // merge header registers
    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } merge_cfg_t;

endpackage

`default_nettype wire

// ===== design/annexb_nal_splitter_top.sv =====
// Released bytes pass through the result register. Throughput: one input byte per
// cycle unless the output stalls; the result register frees as its last byte leaves.
// An end-of-stream beat flushes up to five bytes, one per output beat, and the
// input waits until the last of them is taken (the flush serializer sets this).
// Reset (aresetn low, synchronous) empties the delay line and output register
// and restores the merge headers to 0x67 and 0x68.
// ============================================================================
// annexb_nal_splitter_top - Annex B start code NAL splitter
// Splits a byte stream into packets at start codes, keeping parameter sets
// with the following NAL unit.
// ============================================================================
`default_nettype none

module annexb_nal_splitter_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] stream_byte
    input  wire logic                             s_tlast,   // end_of_stream
    // packet stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,   // [7:0] packet_byte
    output logic                                  m_tlast,   // end_of_packet
    output logic                                  m_tuser,   // [0] run_last
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [anbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data
);
    import anbs_pkg::*;

    merge_cfg_t merge_cfg;
    group_t     group;
    logic       in_accept;

    assign in_accept = s_tvalid && s_tready;

    anbs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .merge_cfg (merge_cfg)
    );

    anbs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_eos    (s_tlast),
        .merge_cfg (merge_cfg),
        .group     (group)
    );

    anbs_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .group     (group),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== design/anbs_cfg.sv =====
// ============================================================================
// anbs_cfg - configuration registers
// Holds the two merge header values, written through the cfg channel.
// ============================================================================
`default_nettype none

module anbs_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [anbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data,
    output anbs_pkg::merge_cfg_t                  merge_cfg
);
    import anbs_pkg::*;

    merge_cfg_t cfg_reg;

    // always able to take a write
    assign cfg_ready = 1'b1;
    assign merge_cfg = cfg_reg;

    // register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first  <= MERGE_FIRST_RST;
            cfg_reg.second <= MERGE_SECOND_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_IDX_MERGE_FIRST) begin
                cfg_reg.first <= cfg_data;
            end
            if (cfg_index == CFG_IDX_MERGE_SECOND) begin
                cfg_reg.second <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/anbs_core.sv =====
// ============================================================================
// anbs_core - start code detection and delay line
// Keeps the four-byte delay line and stream flags, and works out for every
// input beat the group of bytes it releases.
// ============================================================================
`default_nettype none

module anbs_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_accept,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_eos,
    input  wire anbs_pkg::merge_cfg_t merge_cfg,
    output anbs_pkg::group_t          group
);
    import anbs_pkg::*;

    entry_t [HELD_DEPTH-1:0]  held_reg;
    entry_t [HELD_DEPTH-1:0]  held_next;
    logic [HELD_CNT_W-1:0]    held_count_reg;
    logic [HELD_CNT_W-1:0]    held_count_next;
    logic                     seen_reg, seen_next;
    logic                     expect_reg, expect_next;
    logic                     merge_reg, merge_next;

    logic                     zero3, zero2;
    logic                     code4, code3, hit;
    logic [HELD_CNT_W-1:0]    need;
    logic [HELD_CNT_W-1:0]    mark_idx;
    logic                     mark_en;
    logic                     pop;
    entry_t [HELD_DEPTH-1:0]  marked;
    entry_t [HELD_DEPTH-1:0]  shifted;
    logic [HELD_CNT_W-1:0]    n_after_pop;
    logic [HELD_CNT_W-1:0]    n_new;
    logic [COUNT_W-1:0]       grp_count;

    // zero runs just before this byte, at the tail of the delay line
    always_comb begin
        zero3 = 1'b0;
        zero2 = 1'b0;
        case (held_count_reg)
            HELD_CNT_W'(2): begin
                zero2 = (held_reg[0].data == ZERO_BYTE) && (held_reg[1].data == ZERO_BYTE);
            end
            HELD_CNT_W'(3): begin
                zero3 = (held_reg[0].data == ZERO_BYTE) && (held_reg[1].data == ZERO_BYTE)
                     && (held_reg[2].data == ZERO_BYTE);
                zero2 = (held_reg[1].data == ZERO_BYTE) && (held_reg[2].data == ZERO_BYTE);
            end
            HELD_CNT_W'(4): begin
                zero3 = (held_reg[1].data == ZERO_BYTE) && (held_reg[2].data == ZERO_BYTE)
                     && (held_reg[3].data == ZERO_BYTE);
                zero2 = (held_reg[2].data == ZERO_BYTE) && (held_reg[3].data == ZERO_BYTE);
            end
            default: begin
                zero3 = 1'b0;
                zero2 = 1'b0;
            end
        endcase
    end

    // four-byte form wins over three-byte form
    assign code4 = (in_byte == START_BYTE) && zero3;
    assign code3 = (in_byte == START_BYTE) && !zero3 && zero2;
    assign hit   = code4 || code3;
    assign need  = code4 ? HELD_CNT_W'(4) : HELD_CNT_W'(3);

    // cut: mark the byte before the start code, unless first code or merging
    assign mark_en  = hit && seen_reg && !merge_reg && (held_count_reg >= need);
    assign mark_idx = held_count_reg - need;

    always_comb begin
        for (int i = 0; i < HELD_DEPTH; i++) begin
            marked[i]     = held_reg[i];
            marked[i].eop = held_reg[i].eop || (mark_en && (mark_idx == HELD_CNT_W'(i)));
        end
    end

    // oldest byte leaves when the line is full; new byte goes in at the tail
    assign pop         = (held_count_reg == HELD_CNT_W'(HELD_DEPTH));
    assign n_after_pop = pop ? HELD_CNT_W'(HELD_DEPTH - 1) : held_count_reg;
    assign n_new       = n_after_pop + HELD_CNT_W'(1);

    always_comb begin
        for (int i = 0; i < HELD_DEPTH - 1; i++) begin
            if (pop) begin
                shifted[i] = marked[i + 1];
            end else begin
                shifted[i] = marked[i];
            end
        end
        shifted[HELD_DEPTH-1] = marked[HELD_DEPTH-1];
        for (int i = 0; i < HELD_DEPTH; i++) begin
            if (n_after_pop == HELD_CNT_W'(i)) begin
                shifted[i].data = in_byte;
                shifted[i].eop  = 1'b0;
            end
        end
    end

    // results: the popped byte, then the whole line on end of stream
    assign grp_count = COUNT_W'(pop) + (in_eos ? COUNT_W'(n_new) : COUNT_W'(0));

    always_comb begin
        if (pop) begin
            group.entry[0] = marked[0];
        end else begin
            group.entry[0] = shifted[0];
        end
        for (int k = 1; k < HELD_DEPTH; k++) begin
            if (pop) begin
                group.entry[k] = shifted[k - 1];
            end else begin
                group.entry[k] = shifted[k];
            end
        end
        if (pop) begin
            group.entry[HELD_DEPTH] = shifted[HELD_DEPTH-1];
        end else begin
            group.entry[HELD_DEPTH] = '0;
        end
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (in_eos && (grp_count == COUNT_W'(k + 1))) begin
                group.entry[k].eop = 1'b1;
            end
        end
        group.count = grp_count;
    end

    // stream flags
    always_comb begin
        seen_next       = seen_reg;
        expect_next     = expect_reg;
        merge_next      = merge_reg;
        held_next       = shifted;
        held_count_next = n_new;
        if (hit) begin
            seen_next   = 1'b1;
            merge_next  = 1'b0;
            expect_next = 1'b1;
        end else if (expect_reg) begin
            merge_next  = (in_byte == merge_cfg.first) || (in_byte == merge_cfg.second);
            expect_next = 1'b0;
        end
        if (in_eos) begin
            seen_next       = 1'b0;
            expect_next     = 1'b0;
            merge_next      = 1'b0;
            held_count_next = '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
            seen_reg       <= 1'b0;
            expect_reg     <= 1'b0;
            merge_reg      <= 1'b0;
        end else if (in_accept) begin
            held_count_reg <= held_count_next;
            seen_reg       <= seen_next;
            expect_reg     <= expect_next;
            merge_reg      <= merge_next;
        end
    end

    // delay line payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            held_reg <= held_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= HELD_CNT_W'(HELD_DEPTH))
        else $error("delay line count out of range");

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_eos) |=> (held_count_reg == '0) && !seen_reg && !merge_reg)
        else $error("end of stream did not clear stream state");

    a_flags_need_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (merge_reg || expect_reg) |-> seen_reg)
        else $error("header flags set before any start code");

endmodule

`default_nettype wire

// ===== design/anbs_obuf.sv =====
// ============================================================================
// anbs_obuf - result register and flush serializer
// Holds the group released by one input beat and hands it out one byte per
// output beat; takes the next input beat when empty or as its last byte leaves.
// ============================================================================
`default_nettype none

module anbs_obuf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire anbs_pkg::group_t     group,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast,
    output logic                      m_tuser
);
    import anbs_pkg::*;

    entry_t [MAX_RESULTS-1:0] grp_reg;
    entry_t [MAX_RESULTS-1:0] grp_next;
    logic [COUNT_W-1:0]       rem_reg;
    logic [COUNT_W-1:0]       rem_next;
    logic                     out_beat;
    logic                     load;

    assign out_beat = m_tvalid && m_tready;
    // free when empty, or when the last byte goes out this cycle
    assign in_ready = (rem_reg == '0) || ((rem_reg == COUNT_W'(1)) && m_tready);
    assign load     = in_valid && in_ready;

    assign m_tvalid = (rem_reg != '0);
    assign m_tdata  = grp_reg[0].data;
    assign m_tlast  = grp_reg[0].eop;
    assign m_tuser  = (rem_reg == COUNT_W'(1));

    // load a new group or shift the current one down
    always_comb begin
        grp_next = grp_reg;
        rem_next = rem_reg;
        if (load) begin
            grp_next = group.entry;
            rem_next = group.count;
        end else if (out_beat) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                grp_next[k] = grp_reg[k + 1];
            end
            rem_next = rem_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
    end

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= COUNT_W'(MAX_RESULTS))
        else $error("result count out of range");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (group.count != '0)) |=> m_tvalid && (rem_reg == $past(group.count)))
        else $error("loaded group not presented");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(grp_reg[0]) && $stable(rem_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire
